/* rtl/vsc_pkg.sv */
`timescale 1ns / 1ps

package vsc_pkg;

    // Pore shape selector
    typedef enum logic [1:0] {
        SHAPE_SPHERE = 2'd0,
        SHAPE_CAP    = 2'd1,
        SHAPE_SLOT   = 2'd2,
        SHAPE_CYL    = 2'd3
    } shape_t;

    // Configuration register map
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE_KIND    = 3'd0,
        REG_SLOPE_X       = 3'd1,
        REG_OFFSET_B      = 3'd2,
        REG_SLOPE_Z       = 3'd3,
        REG_CENTER_X      = 3'd4,
        REG_CENTER_Y      = 3'd5,
        REG_CENTER_Z      = 3'd6,
        REG_SPHERE_RADIUS = 3'd7
    } cfg_reg_t;

    // Result stream is one byte wide
    localparam int OUT_TDATA_W = 8;

    // Partial product budget per pipeline stage (operand bits squared)
    localparam int MUL_AREA = 1024;

endpackage

/* rtl/vsc_dly.sv */
`timescale 1ns / 1ps

// Payload delay line that moves in step with the pipeline enable
module vsc_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift one place per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

/* rtl/vsc_mul.sv */
`timescale 1ns / 1ps

// Pipelined signed multiplier. Operand b is cut into NCH chunks; each stage
// multiplies a by one chunk and adds it into the running sum.
module vsc_mul #(
    parameter int AW  = 34,
    parameter int BW  = 34,
    parameter int NCH = 2
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int CW = (BW + NCH - 1) / NCH;
    localparam int XW = NCH * CW;
    localparam int SW = AW + XW + 1;

    logic signed [AW-1:0] a_pipe_reg [NCH];
    logic signed [XW-1:0] b_pipe_reg [NCH];
    logic signed [SW-1:0] sum_reg    [NCH];
    logic signed [SW-1:0] term       [NCH];

    // Partial product of each stage: low chunks unsigned, top chunk signed
    always_comb
    begin
        logic signed [CW:0]    chk;
        logic signed [AW+CW:0] prod;
        for (int k = 0; k < NCH; k++)
        begin
            chk = {((k == NCH - 1) ? b_pipe_reg[k][k*CW+CW-1] : 1'b0),
                   b_pipe_reg[k][k*CW +: CW]};
            prod = a_pipe_reg[k] * chk;
            term[k] = SW'(prod) <<< (k * CW);
        end
    end

    // Operand carry and accumulate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pipe_reg[0] <= a;
            b_pipe_reg[0] <= XW'(b);
            sum_reg[0]    <= term[0];
            for (int k = 1; k < NCH; k++)
            begin
                a_pipe_reg[k] <= a_pipe_reg[k-1];
                b_pipe_reg[k] <= b_pipe_reg[k-1];
                sum_reg[k]    <= sum_reg[k-1] + term[k];
            end
        end
    end

    assign p = sum_reg[NCH-1][AW+BW-1:0];

endmodule

/* rtl/voxel_shape_classifier.sv */
`timescale 1ns / 1ps

// Channel    Dir  Fields (low bit first)
// s_axis     in   tdata: point_x, point_y, point_z (COORD_WIDTH each, signed)
// m_axis     out  tdata: solid (bit 0), zero fill to one byte
// cfg        in   cfg_we / cfg_index / cfg_data, one register per write
//
// One point per cycle while the skid register is empty; each point passes
// through two chunked multiplier banks (first-order products, then squares
// of the cross terms and cap offset, and the b-squared direction product).
// Reset clears config registers, stage valids and the output and skid valid flags.
// A result refused downstream parks in a skid register; the pipeline and
// s_axis_tready halt only while that skid register is full.
module voxel_shape_classifier #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // point_x, point_y, point_z, zero fill to whole bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // solid, zero fill
    output logic [vsc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic [vsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_WIDTH-1:0]                cfg_data
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int WA  = W + 2;
    localparam int PA  = 2 * WA;
    localparam int WB0 = (2 * WA > W + F + 3) ? 2 * WA : W + F + 3;
    localparam int WB  = ((WB0 > 2 * F + 1) ? WB0 : 2 * F + 1) + 2;
    localparam int PB  = 2 * WB;
    localparam int WF  = PB + 2;
    localparam int NA  = (WA * WA + vsc_pkg::MUL_AREA - 1) / vsc_pkg::MUL_AREA;
    localparam int NB  = (WB * WB + vsc_pkg::MUL_AREA - 1) / vsc_pkg::MUL_AREA;
    localparam int LAT_A = NA + 1;
    localparam int LAT_B = NB + 1;
    localparam int NV  = LAT_A + LAT_B + 5;
    localparam int DA_W = W + 2 * WA;
    localparam int DB_W = 3 + 2 * WB;
    localparam logic signed [WB-1:0] ONE2 = WB'(1) <<< (2 * F);

    // ------------------------------------------------------------------
    // Configuration registers
    vsc_pkg::shape_t         shape_kind_reg;
    logic signed [W-1:0]     slope_x_reg;
    logic signed [W-1:0]     offset_b_reg;
    logic signed [W-1:0]     slope_z_reg;
    logic signed [W-1:0]     center_x_reg;
    logic signed [W-1:0]     center_y_reg;
    logic signed [W-1:0]     center_z_reg;
    logic [W-2:0]            sphere_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg    <= vsc_pkg::SHAPE_SPHERE;
            slope_x_reg       <= '0;
            offset_b_reg      <= '0;
            slope_z_reg       <= '0;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            center_z_reg      <= '0;
            sphere_radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (vsc_pkg::cfg_reg_t'(cfg_index))
                vsc_pkg::REG_SHAPE_KIND:
                    shape_kind_reg <= vsc_pkg::shape_t'(cfg_data[1:0]);
                vsc_pkg::REG_SLOPE_X:       slope_x_reg       <= cfg_data;
                vsc_pkg::REG_OFFSET_B:      offset_b_reg      <= cfg_data;
                vsc_pkg::REG_SLOPE_Z:       slope_z_reg       <= cfg_data;
                vsc_pkg::REG_CENTER_X:      center_x_reg      <= cfg_data;
                vsc_pkg::REG_CENTER_Y:      center_y_reg      <= cfg_data;
                vsc_pkg::REG_CENTER_Z:      center_z_reg      <= cfg_data;
                vsc_pkg::REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // Config values at multiplier operand width
    logic signed [WA-1:0] a_wa, b_wa, c_wa, cx_wa, cz_wa, r_wa;
    assign a_wa  = WA'(slope_x_reg);
    assign b_wa  = WA'(offset_b_reg);
    assign c_wa  = WA'(slope_z_reg);
    assign cx_wa = WA'(center_x_reg);
    assign cz_wa = WA'(center_z_reg);
    assign r_wa  = signed'({3'b000, sphere_radius_reg});

    // ------------------------------------------------------------------
    // Pipeline control: whole pipe advances unless the skid stage is full
    logic pipe_en;
    logic vld_reg [NV];
    logic out_valid_reg, out_valid_next;
    logic out_solid_reg, out_solid_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_solid_reg, skid_solid_next;
    logic solid_reg;

    assign pipe_en       = !skid_valid_reg;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NV; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < NV; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: unpack point, form offsets from centers and cylinder axis
    logic signed [W-1:0]  in_x, in_y, in_z;
    logic signed [WA-1:0] dx_reg, dy_reg, dz_reg, x_reg, z_reg;
    logic signed [WA-1:0] px_reg, py_reg, pz_reg;
    logic signed [W-1:0]  y_reg;

    assign in_x = s_axis_tdata[W-1:0];
    assign in_y = s_axis_tdata[2*W-1:W];
    assign in_z = s_axis_tdata[3*W-1:2*W];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dx_reg <= WA'(in_x) - cx_wa;
            dy_reg <= WA'(in_y) - WA'(center_y_reg);
            dz_reg <= WA'(in_z) - cz_wa;
            x_reg  <= WA'(in_x);
            z_reg  <= WA'(in_z);
            y_reg  <= in_y;
            px_reg <= WA'(in_x) <<< 1;
            py_reg <= (WA'(in_y) - b_wa) <<< 1;
            pz_reg <= (WA'(in_z) <<< 1) - b_wa;
        end
    end

    // ------------------------------------------------------------------
    // First product bank
    logic signed [PA-1:0] dx2, dy2, dz2, ax, cz, acx, ccz;
    logic signed [PA-1:0] pyc, pza, pxc, aa, cc, rr, bb;

    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_dx2
        (.clk(clk), .en(pipe_en), .a(dx_reg), .b(dx_reg), .p(dx2));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_dy2
        (.clk(clk), .en(pipe_en), .a(dy_reg), .b(dy_reg), .p(dy2));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_dz2
        (.clk(clk), .en(pipe_en), .a(dz_reg), .b(dz_reg), .p(dz2));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_ax
        (.clk(clk), .en(pipe_en), .a(a_wa), .b(x_reg), .p(ax));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_cz
        (.clk(clk), .en(pipe_en), .a(c_wa), .b(z_reg), .p(cz));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_acx
        (.clk(clk), .en(pipe_en), .a(a_wa), .b(cx_wa), .p(acx));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_ccz
        (.clk(clk), .en(pipe_en), .a(c_wa), .b(cz_wa), .p(ccz));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_pyc
        (.clk(clk), .en(pipe_en), .a(py_reg), .b(c_wa), .p(pyc));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_pza
        (.clk(clk), .en(pipe_en), .a(pz_reg), .b(a_wa), .p(pza));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_pxc
        (.clk(clk), .en(pipe_en), .a(px_reg), .b(c_wa), .p(pxc));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_aa
        (.clk(clk), .en(pipe_en), .a(a_wa), .b(a_wa), .p(aa));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_cc
        (.clk(clk), .en(pipe_en), .a(c_wa), .b(c_wa), .p(cc));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_rr
        (.clk(clk), .en(pipe_en), .a(r_wa), .b(r_wa), .p(rr));
    vsc_mul #(.AW(WA), .BW(WA), .NCH(NA)) u_m_bb
        (.clk(clk), .en(pipe_en), .a(b_wa), .b(b_wa), .p(bb));

    // Side data alongside the first bank
    logic [DA_W-1:0]      da_out;
    logic signed [W-1:0]  y_d;
    logic signed [WA-1:0] py_d, pz_d;

    vsc_dly #(.WIDTH(DA_W), .DEPTH(LAT_A)) u_dly_a (
        .clk  (clk),
        .en   (pipe_en),
        .din  ({pz_reg, py_reg, y_reg}),
        .dout (da_out)
    );

    assign {pz_d, py_d, y_d} = da_out;

    // ------------------------------------------------------------------
    // Stage S1: sums of first products
    logic signed [WB-1:0] sph_reg, dxz_reg, base_reg, capy_reg;
    logic signed [WB-1:0] cylx_reg, cyly_reg, cylz_reg, dir2_reg;
    logic signed [WB-1:0] ys_reg, rr_reg, bb_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sph_reg  <= WB'(dx2) + WB'(dy2) + WB'(dz2);
            dxz_reg  <= WB'(dx2) + WB'(dz2);
            base_reg <= WB'(ax) + WB'(cz);
            capy_reg <= WB'(acx) + WB'(ccz);
            cylx_reg <= WB'(pyc) - WB'(pza);
            cyly_reg <= (WB'(pz_d) <<< F) - WB'(pxc);
            cylz_reg <= (WB'(ax) <<< 1) - (WB'(py_d) <<< F);
            dir2_reg <= ONE2 + WB'(aa) + WB'(cc);
            ys_reg   <= WB'(y_d) <<< F;
            rr_reg   <= WB'(rr);
            bb_reg   <= WB'(bb);
        end
    end

    // ------------------------------------------------------------------
    // Stage S2: plane side tests, cap offset, sphere decision
    logic                 sph_in_reg, above_reg, below_top_reg;
    logic signed [WB-1:0] ydiff_reg, dxz2_reg, bb2_reg;
    logic signed [WB-1:0] cx2_reg, cy2_reg, cz2_reg, dir2b_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sph_in_reg    <= sph_reg < rr_reg;
            above_reg     <= ys_reg > base_reg;
            below_top_reg <= ys_reg < base_reg + (WB'(offset_b_reg) <<< F);
            ydiff_reg     <= ys_reg - capy_reg;
            dxz2_reg      <= dxz_reg;
            bb2_reg       <= bb_reg;
            cx2_reg       <= cylx_reg;
            cy2_reg       <= cyly_reg;
            cz2_reg       <= cylz_reg;
            dir2b_reg     <= dir2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Second product bank: squares of cross terms and cap offset, and bb times dir2
    logic signed [PB-1:0] ysq, cxsq, cysq, czsq, bdir;

    vsc_mul #(.AW(WB), .BW(WB), .NCH(NB)) u_m_ysq
        (.clk(clk), .en(pipe_en), .a(ydiff_reg), .b(ydiff_reg), .p(ysq));
    vsc_mul #(.AW(WB), .BW(WB), .NCH(NB)) u_m_cxsq
        (.clk(clk), .en(pipe_en), .a(cx2_reg), .b(cx2_reg), .p(cxsq));
    vsc_mul #(.AW(WB), .BW(WB), .NCH(NB)) u_m_cysq
        (.clk(clk), .en(pipe_en), .a(cy2_reg), .b(cy2_reg), .p(cysq));
    vsc_mul #(.AW(WB), .BW(WB), .NCH(NB)) u_m_czsq
        (.clk(clk), .en(pipe_en), .a(cz2_reg), .b(cz2_reg), .p(czsq));
    vsc_mul #(.AW(WB), .BW(WB), .NCH(NB)) u_m_bdir
        (.clk(clk), .en(pipe_en), .a(bb2_reg), .b(dir2b_reg), .p(bdir));

    logic [DB_W-1:0]      db_out;
    logic                 sph_in_d, above_d, below_top_d;
    logic signed [WB-1:0] dxz_d, bb_d;

    vsc_dly #(.WIDTH(DB_W), .DEPTH(LAT_B)) u_dly_b (
        .clk  (clk),
        .en   (pipe_en),
        .din  ({bb2_reg, dxz2_reg, below_top_reg, above_reg, sph_in_reg}),
        .dout (db_out)
    );

    assign {bb_d, dxz_d, below_top_d, above_d, sph_in_d} = db_out;

    // ------------------------------------------------------------------
    // Stage S3: squared distances for cap and cylinder
    logic signed [WF-1:0] cyl_lhs_reg, cyl_rhs_reg, cap_d2_reg, cap_rhs_reg;
    logic                 sph_in3_reg, above3_reg, below_top3_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cyl_lhs_reg    <= WF'(cxsq) + WF'(cysq) + WF'(czsq);
            cyl_rhs_reg    <= WF'(bdir);
            cap_d2_reg     <= (WF'(dxz_d) <<< (2 * F)) + WF'(ysq);
            cap_rhs_reg    <= WF'(bb_d) <<< (2 * F);
            sph_in3_reg    <= sph_in_d;
            above3_reg     <= above_d;
            below_top3_reg <= below_top_d;
        end
    end

    // ------------------------------------------------------------------
    // Stage S4: shape select
    logic b_nonneg;
    logic in_pore;

    assign b_nonneg = !offset_b_reg[W-1];

    always_comb
    begin
        case (shape_kind_reg)
            vsc_pkg::SHAPE_SPHERE: in_pore = sph_in3_reg;
            vsc_pkg::SHAPE_CAP:    in_pore = above3_reg && b_nonneg &&
                                             (cap_d2_reg <= cap_rhs_reg);
            vsc_pkg::SHAPE_SLOT:   in_pore = above3_reg && below_top3_reg;
            vsc_pkg::SHAPE_CYL:    in_pore = b_nonneg && (cyl_lhs_reg <= cyl_rhs_reg);
            default:               in_pore = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            solid_reg <= !in_pore;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    logic push, pop;

    assign push = pipe_en && vld_reg[NV-1];
    assign pop  = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_solid_next  = out_solid_reg;
        skid_valid_next = skid_valid_reg;
        skid_solid_next = skid_solid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_solid_next  = skid_solid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_solid_next = solid_reg;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_solid_next = solid_reg;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_solid_reg  <= out_solid_next;
        skid_solid_reg <= skid_solid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(vsc_pkg::OUT_TDATA_W-1){1'b0}}, out_solid_reg};

`ifndef NO_ASSERTIONS
    // Skid holds a result only behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output empty");

    // A result arriving at a stalled output must land in the skid stage
    a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("result dropped at stalled output");

    // Draining the skid stage keeps the output valid
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_axis_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid drain lost a result");

    // Frozen pipeline keeps its last-stage valid
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg[NV-1]))
        else $error("pipeline moved while stalled");
`endif

endmodule
